FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: src/swdr_pkg.sv
//------------------------------------------------------------------------------
// swdr_pkg
// Types and constants of the sliding-window detrended RMS block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package swdr_pkg;
    localparam int MaxWindowDef   = 256;
    localparam int SampleWidthDef = 24;
    localparam int PosWidth       = 24;
    localparam int WlenWidth      = 9;
    localparam logic [WlenWidth-1:0] WlenReset = 9'd16;
    localparam logic [WlenWidth-1:0] WlenMin   = 9'd3;
    localparam int SumWidth       = 64;
    localparam int AccWidth       = 64;
    localparam logic [0:0] RegWindowLength = 1'b0;
endpackage

FILE: src/sliding_window_detrended_rms.sv
// Flow from sample transfer to result transfer: build the job in the front end, square,
// 128-step division, 32-step square root, 32-step scale by W; the division is skipped
// when every time value in the window is equal.
// Samples that yield no result, before the window has filled, stay in the front end.
// The front end holds one finished job while the back end works, then stalls its input.
// Reset (synchronous, active low) clears sums, counters and sets window length 16.
`timescale 1ns / 1ps
module sliding_window_detrended_rms
    import swdr_pkg::*;
#(
    parameter int MAX_WINDOW   = MaxWindowDef,
    parameter int SAMPLE_WIDTH = SampleWidthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [0:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_time_value,
    input  logic [SAMPLE_WIDTH-1:0] i_profile_value,
    input  logic                    i_start_of_series,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PosWidth-1:0]     o_fluctuation,
    output logic [PosWidth-1:0]     o_window_start
);
    logic [WlenWidth-1:0] r_wlen;
    logic r_restart;
    logic done, jv, js;
    logic [AccWidth-1:0] ja, jb, jc;
    logic [PosWidth-1:0] jst;

    assign pready = 1'b1;
    assign prdata = (paddr == RegWindowLength) ? 32'(r_wlen) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WlenReset;
            r_restart <= 1'b0;
        end else if (psel && penable && pwrite && paddr == RegWindowLength) begin
            r_wlen <= pwdata[WlenWidth-1:0];
            r_restart <= 1'b1;
        end else if (done) begin
            r_restart <= 1'b0;
        end
    end

    swdr_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_time_value, .i_profile_value, .i_start_of_series,
        .i_wlen(r_wlen), .i_restart(r_restart), .o_restart_done(done),
        .o_job_valid(jv), .i_job_stall(js),
        .o_job_a(ja), .o_job_b(jb), .o_job_c(jc), .o_job_start(jst)
    );

    swdr_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .o_job_stall(js),
        .i_job_a(ja), .i_job_b(jb), .i_job_c(jc), .i_job_start(jst),
        .i_w(r_wlen), .o_valid, .i_stall, .o_fluctuation, .o_window_start
    );
endmodule

FILE: src/swdr_front.sv
//------------------------------------------------------------------------------
// swdr_front
// Window ring, running sums and centered sums; emits jobs to the back end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swdr_front
    import swdr_pkg::*;
#(
    parameter int MAX_WINDOW   = MaxWindowDef,
    parameter int SAMPLE_WIDTH = SampleWidthDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [SAMPLE_WIDTH-1:0]     i_time_value,
    input  logic [SAMPLE_WIDTH-1:0]     i_profile_value,
    input  logic                        i_start_of_series,
    input  logic [WlenWidth-1:0]        i_wlen,
    input  logic                        i_restart,
    output logic                        o_restart_done,
    output logic                        o_job_valid,
    input  logic                        i_job_stall,
    output logic [AccWidth-1:0]         o_job_a,
    output logic [AccWidth-1:0]         o_job_b,
    output logic [AccWidth-1:0]         o_job_c,
    output logic [PosWidth-1:0]         o_job_start
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_READ = 6'b000010, S_SUB = 6'b000100,
        S_ADD = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [SAMPLE_WIDTH-1:0] r_tring [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_yring [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_ot, r_oy, r_t, r_y;
    logic [SumWidth-1:0] r_st, r_sy, r_stt, r_sty, r_syy;
    logic [SumWidth-1:0] r_p0, r_p1, r_p2;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_wp;
    logic [PosWidth-1:0] r_pos, r_cur;
    logic [CW-1:0] r_w;
    logic r_full;
    logic [2:0] r_k;

    logic [CW-1:0] w_eff;
    logic [SumWidth-1:0] ws_t, ws_y, ot_s, oy_s;
    logic [AW-1:0] old_idx;
    logic [31:0] idx_sum;
    logic signed [2*SAMPLE_WIDTH-1:0] p_ott, p_oty, p_oyy, p_ntt, p_nty, p_nyy;
    logic [31:0] mx0, my0, mx1, my1, mx2, my2;
    logic [63:0] m0, m1, m2;

    always_comb begin
        if (i_wlen < WlenMin) begin
            w_eff = CW'(WlenMin);
        end else if (32'(i_wlen) > MAX_WINDOW) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(i_wlen);
        end
    end

    assign ws_t = SumWidth'(signed'(r_t));
    assign ws_y = SumWidth'(signed'(r_y));
    assign ot_s = SumWidth'(signed'(r_ot));
    assign oy_s = SumWidth'(signed'(r_oy));
    assign idx_sum = 32'(r_wp) + 32'(MAX_WINDOW) - 32'(r_w);
    assign old_idx = (idx_sum >= 32'(MAX_WINDOW)) ? AW'(idx_sum - 32'(MAX_WINDOW))
                                                   : AW'(idx_sum);

    assign p_ott = signed'(r_ot) * signed'(r_ot);
    assign p_oty = signed'(r_ot) * signed'(r_oy);
    assign p_oyy = signed'(r_oy) * signed'(r_oy);
    assign p_ntt = signed'(r_t) * signed'(r_t);
    assign p_nty = signed'(r_t) * signed'(r_y);
    assign p_nyy = signed'(r_y) * signed'(r_y);

    // W*S2 - S1a*S1b modulo 2^64, one 32x32 partial product per lane per cycle
    always_comb begin
        mx0 = '0; my0 = '0; mx1 = '0; my1 = '0; mx2 = '0; my2 = '0;
        case (r_k)
            3'd0: begin
                mx0 = 32'(r_w); my0 = r_stt[31:0];
                mx1 = 32'(r_w); my1 = r_sty[31:0];
                mx2 = 32'(r_w); my2 = r_syy[31:0];
            end
            3'd1: begin
                mx0 = 32'(r_w); my0 = r_stt[63:32];
                mx1 = 32'(r_w); my1 = r_sty[63:32];
                mx2 = 32'(r_w); my2 = r_syy[63:32];
            end
            3'd2: begin
                mx0 = r_st[31:0]; my0 = r_st[31:0];
                mx1 = r_st[31:0]; my1 = r_sy[31:0];
                mx2 = r_sy[31:0]; my2 = r_sy[31:0];
            end
            3'd3: begin
                mx0 = r_st[31:0]; my0 = r_st[63:32];
                mx1 = r_st[31:0]; my1 = r_sy[63:32];
                mx2 = r_sy[31:0]; my2 = r_sy[63:32];
            end
            3'd4: begin
                mx0 = r_st[63:32]; my0 = r_st[31:0];
                mx1 = r_st[63:32]; my1 = r_sy[31:0];
                mx2 = r_sy[63:32]; my2 = r_sy[31:0];
            end
            default: ;
        endcase
    end

    assign m0 = mx0 * my0;
    assign m1 = mx1 * my1;
    assign m2 = mx2 * my2;

    assign o_stall = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_restart_done = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_SUB;
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = (r_fill >= r_w) ? S_MUL : S_IDLE;
            S_MUL:  if (r_k == 3'd4) n_state = S_OUT;
            S_OUT:  if (!i_job_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st <= '0; r_sy <= '0; r_stt <= '0; r_sty <= '0; r_syy <= '0;
            r_fill <= '0; r_wp <= '0; r_pos <= '0;
            r_w <= CW'(WlenReset); r_full <= 1'b0; r_k <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_t <= i_time_value;
                    r_y <= i_profile_value;
                    r_w <= w_eff;
                    if (i_start_of_series || i_restart) begin
                        r_st <= '0; r_sy <= '0; r_stt <= '0; r_sty <= '0; r_syy <= '0;
                        r_fill <= '0; r_wp <= '0; r_pos <= '0;
                    end
                end
                S_READ: begin
                    r_full <= (r_fill >= r_w);
                    r_ot <= r_tring[old_idx];
                    r_oy <= r_yring[old_idx];
                    r_tring[r_wp] <= r_t;
                    r_yring[r_wp] <= r_y;
                    r_wp <= (32'(r_wp) == 32'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                    r_cur <= r_pos;
                    r_pos <= r_pos + 1'b1;
                end
                S_SUB: begin
                    if (r_full) begin
                        r_st <= r_st - ot_s;
                        r_sy <= r_sy - oy_s;
                        r_p0 <= SumWidth'(p_ott);
                        r_p1 <= SumWidth'(p_oty);
                        r_p2 <= SumWidth'(p_oyy);
                    end else begin
                        r_fill <= r_fill + 1'b1;
                        r_p0 <= '0; r_p1 <= '0; r_p2 <= '0;
                    end
                end
                S_ADD: begin
                    r_st <= r_st + ws_t;
                    r_sy <= r_sy + ws_y;
                    r_stt <= r_stt - r_p0 + SumWidth'(p_ntt);
                    r_sty <= r_sty - r_p1 + SumWidth'(p_nty);
                    r_syy <= r_syy - r_p2 + SumWidth'(p_nyy);
                    r_k <= '0;
                end
                S_MUL: begin
                    case (r_k)
                        3'd0: begin
                            r_p0 <= m0;
                            r_p1 <= m1;
                            r_p2 <= m2;
                        end
                        3'd1: begin
                            r_p0 <= r_p0 + {m0[31:0], 32'd0};
                            r_p1 <= r_p1 + {m1[31:0], 32'd0};
                            r_p2 <= r_p2 + {m2[31:0], 32'd0};
                        end
                        3'd2: begin
                            r_p0 <= r_p0 - m0;
                            r_p1 <= r_p1 - m1;
                            r_p2 <= r_p2 - m2;
                        end
                        3'd3: begin
                            r_p0 <= r_p0 - {m0[31:0], 32'd0};
                            r_p1 <= r_p1 - {m1[31:0], 32'd0};
                            r_p2 <= r_p2 - {m2[31:0], 32'd0};
                        end
                        default: begin
                            o_job_a <= r_p0 - {m0[31:0], 32'd0};
                            o_job_b <= r_p1 - {m1[31:0], 32'd0};
                            o_job_c <= r_p2 - {m2[31:0], 32'd0};
                            o_job_start <= r_cur - PosWidth'(r_w) + 1'b1;
                        end
                    endcase
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_job_hold, i_clk, i_rst_n,
        (o_job_valid && i_job_stall) |=> o_job_valid)
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n,
        (r_state == S_IDLE && i_valid) |=> o_stall)
    `ASSERT_NEVER(a_fill_over, i_clk, i_rst_n, r_fill > CW'(MAX_WINDOW))
endmodule

FILE: src/swdr_back.sv
//------------------------------------------------------------------------------
// swdr_back
// Residual sum, long division, integer square root and window scaling.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swdr_back
    import swdr_pkg::*;
#(
    parameter int MAX_WINDOW   = MaxWindowDef,
    parameter int SAMPLE_WIDTH = SampleWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_stall,
    input  logic [AccWidth-1:0]  i_job_a,
    input  logic [AccWidth-1:0]  i_job_b,
    input  logic [AccWidth-1:0]  i_job_c,
    input  logic [PosWidth-1:0]  i_job_start,
    input  logic [WlenWidth-1:0] i_w,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PosWidth-1:0]  o_fluctuation,
    output logic [PosWidth-1:0]  o_window_start
);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [31:0] SatLimit = (SAMPLE_WIDTH >= PosWidth) ? 32'h00FF_FFFF :
        32'((64'd1 << SAMPLE_WIDTH) - 64'd1);
    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001, B_SQ = 8'b00000010, B_DIV = 8'b00000100,
        B_RES = 8'b00001000, B_SQRT = 8'b00010000, B_SCL = 8'b00100000,
        B_SDIV = 8'b01000000, B_OUT = 8'b10000000
    } t_state;

    t_state r_state;
    logic [63:0] r_a, r_b, r_c, r_lo, r_hi, r_q, r_r, r_x, r_res, r_one;
    logic [31:0] r_m0, r_m1, r_m2, r_m3;
    logic [6:0]  r_i;
    logic r_big;
    logic [CW-1:0] r_w;
    logic [PosWidth-1:0] r_start;
    logic [31:0] r_sq, r_sr, r_sq_q;
    logic [5:0] r_k;
    logic [64:0] rsh;
    logic bit_in;
    logic [63:0] sum1;
    logic [32:0] srs;

    assign o_job_stall = (r_state != B_IDLE);
    assign o_valid = (r_state == B_OUT);
    assign bit_in = r_i[6] ? r_hi[r_i[5:0]] : r_lo[r_i[5:0]];
    assign rsh = {r_r, bit_in};
    assign sum1 = r_res + r_one;
    assign srs = {r_sr, r_sq[r_k[4:0]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: if (i_job_valid) begin
                    r_a <= i_job_a[63] ? 64'd0 : i_job_a;
                    r_c <= i_job_c[63] ? 64'd0 : i_job_c;
                    r_b <= i_job_b[63] ? -i_job_b : i_job_b;
                    r_start <= i_job_start;
                    r_w <= (i_w < WlenMin) ? CW'(WlenMin) :
                        (32'(i_w) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(i_w);
                    r_state <= B_SQ;
                    r_i <= 7'd0;
                end
                B_SQ: begin
                    // three 32x32 partial products (cross term doubled), then combine
                    if (r_i == 7'd0) begin
                        {r_m1, r_m0} <= r_b[31:0] * r_b[31:0];
                        r_i <= 7'd1;
                    end else if (r_i == 7'd1) begin
                        r_lo <= {r_m1, r_m0};
                        r_hi <= '0;
                        {r_m3, r_m2} <= r_b[31:0] * r_b[63:32];
                        r_i <= 7'd2;
                    end else if (r_i == 7'd2) begin
                        {r_hi, r_lo} <= {r_hi, r_lo} + {31'd0, r_m3, r_m2, 33'd0};
                        {r_m3, r_m2} <= r_b[63:32] * r_b[63:32];
                        r_i <= 7'd3;
                    end else begin
                        r_hi <= r_hi + {r_m3, r_m2};
                        r_q <= '0; r_r <= '0; r_big <= 1'b0;
                        r_i <= 7'd127;
                        r_state <= (r_a == 64'd0) ? B_RES : B_DIV;
                    end
                end
                B_DIV: begin
                    if (rsh[64] || rsh[63:0] >= r_a) begin
                        r_r <= rsh[63:0] - r_a;
                        if (r_i[6]) r_big <= 1'b1;
                        else r_q[r_i[5:0]] <= 1'b1;
                    end else begin
                        r_r <= rsh[63:0];
                    end
                    r_i <= r_i - 1'b1;
                    if (r_i == 7'd0) r_state <= B_RES;
                end
                B_RES: begin
                    if (r_a == 64'd0) r_x <= r_c;
                    else r_x <= (r_big || r_q > r_c) ? 64'd0 : r_c - r_q;
                    r_res <= '0;
                    r_one <= 64'd1 << 62;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    if (r_x >= sum1) begin
                        r_x <= r_x - sum1;
                        r_res <= (r_res >> 1) + r_one;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_one <= r_one >> 2;
                    if (r_one[0]) r_state <= B_SCL;
                end
                B_SCL: begin
                    r_sq <= r_res[31:0];
                    r_sr <= '0; r_sq_q <= '0; r_k <= 6'd31;
                    r_state <= B_SDIV;
                end
                B_SDIV: begin
                    if (srs >= 33'(r_w)) begin
                        r_sr <= 32'(srs - 33'(r_w));
                        r_sq_q[r_k[4:0]] <= 1'b1;
                    end else begin
                        r_sr <= srs[31:0];
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == 6'd0) r_state <= B_OUT;
                end
                B_OUT: if (!i_stall) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_fluctuation = (r_sq_q > SatLimit) ? PosWidth'(SatLimit) : r_sq_q[PosWidth-1:0];
    assign o_window_start = r_start;

    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(o_fluctuation))
    `ASSERT_IMPL(a_busy, i_clk, i_rst_n, (r_state == B_IDLE && i_job_valid) |=> o_job_stall)
    `ASSERT_NEVER(a_w_small, i_clk, i_rst_n, (r_state != B_IDLE) && (r_w < CW'(WlenMin)))
endmodule

FILE: test/swdr_checker.sv
//------------------------------------------------------------------------------
// swdr_checker
// Watches the config port and both sample/result channels of the detrended
// RMS block, predicts each result and compares it field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module swdr_checker
    import swdr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [0:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [23:0]          i_time_value,
    input  logic [23:0]          i_profile_value,
    input  logic                 i_start_of_series,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [PosWidth-1:0]  i_fluctuation,
    input  logic [PosWidth-1:0]  i_window_start,
    output int                   o_fail_count,
    output int                   o_pending
);
    localparam int RingDepth = MaxWindowDef;

    typedef struct packed {
        logic [PosWidth-1:0] fluct;
        logic [PosWidth-1:0] wstart;
    } t_fluct_result;

    t_fluct_result   fluct_q[$];
    logic [63:0]     ring_t[RingDepth];
    logic [63:0]     ring_y[RingDepth];
    logic [63:0]     acc_t, acc_y, acc_tt, acc_ty, acc_yy;
    logic [8:0]      fill, wlen;
    logic [7:0]      wptr;
    logic [23:0]     spos;
    logic            restart;
    int              fails;
    int              shown;

    assign o_fail_count = fails;
    assign o_pending    = fluct_q.size();

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x) one = one >> 2;
        while (one != 0) begin
            if (x >= res + one) begin
                x   = x - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    task automatic clear_window();
        acc_t = 0; acc_y = 0; acc_tt = 0; acc_ty = 0; acc_yy = 0;
        fill = 0; wptr = 0; spos = 0;
    endtask

    task automatic predict_sample(logic [23:0] tv, logic [23:0] yv, logic sos);
        logic [63:0]  t, y, ww, ot, oy, a, b, c, babs, r, f;
        logic [127:0] sq, q;
        logic [8:0]   w;
        logic [7:0]   old;
        logic [23:0]  pos;
        t_fluct_result res;
        t  = {{40{tv[23]}}, tv};
        y  = {{40{yv[23]}}, yv};
        w  = (wlen < 9'd3) ? 9'd3 : (wlen > 9'd256 ? 9'd256 : wlen);
        ww = 64'(w);
        if (sos || restart) begin
            clear_window();
            restart = 1'b0;
        end
        if (fill >= w) begin
            old = 8'(wptr - w);
            ot = ring_t[old];
            oy = ring_y[old];
            acc_t  -= ot;
            acc_y  -= oy;
            acc_tt -= ot * ot;
            acc_ty -= ot * oy;
            acc_yy -= oy * oy;
        end else begin
            fill++;
        end
        ring_t[wptr] = t;
        ring_y[wptr] = y;
        wptr++;
        acc_t  += t;
        acc_y  += y;
        acc_tt += t * t;
        acc_ty += t * y;
        acc_yy += y * y;
        pos  = spos;
        spos = spos + 24'd1;
        if (fill >= w) begin
            a = ww * acc_tt - acc_t * acc_t;
            b = ww * acc_ty - acc_t * acc_y;
            c = ww * acc_yy - acc_y * acc_y;
            if (a[63]) a = 0;
            if (c[63]) c = 0;
            babs = b[63] ? -b : b;
            if (a == 0) begin
                r = c;
            end else begin
                sq = {64'd0, babs} * {64'd0, babs};
                q  = sq / {64'd0, a};
                r  = (q[127:64] != 0 || q[63:0] > c) ? 64'd0 : c - q[63:0];
            end
            f = isqrt(r) / ww;
            if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
            res.fluct  = f[23:0];
            res.wstart = pos - 24'(w) + 24'd1;
            fluct_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_fluct_result exp_r;
        if (!i_rst_n) begin
            clear_window();
            wlen    <= WlenReset;
            restart <= 1'b0;
            fails   <= 0;
            shown   <= 0;
            fluct_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == RegWindowLength) begin
                wlen    = i_pwdata[8:0];
                restart = 1'b1;
            end
            if (i_in_valid && !i_in_stall)
                predict_sample(i_time_value, i_profile_value, i_start_of_series);
            if (i_out_valid && !i_out_stall) begin
                if (fluct_q.size() == 0) begin
                    fails = fails + 1;
                    if (shown < 10) begin
                        $display("unexpected result fluct=%h wstart=%h",
                                 i_fluctuation, i_window_start);
                        shown = shown + 1;
                    end
                end else begin
                    exp_r = fluct_q.pop_front();
                    if (exp_r.fluct !== i_fluctuation || exp_r.wstart !== i_window_start) begin
                        fails = fails + 1;
                        if (shown < 10) begin
                            $display("mismatch: fluct exp %h got %h, wstart exp %h got %h",
                                     exp_r.fluct, i_fluctuation, exp_r.wstart, i_window_start);
                            shown = shown + 1;
                        end
                    end
                end
            end
        end
    end
endmodule

FILE: test/tb_sliding_window_detrended_rms.sv
//------------------------------------------------------------------------------
// tb_sliding_window_detrended_rms
// Drives sample series through the detrended RMS block under several window
// lengths with random idling and back-pressure; the checker judges results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sliding_window_detrended_rms;
    import swdr_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int SettleCycles = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [23:0] i_time_value, i_profile_value;
    logic        i_start_of_series;
    logic        o_valid, i_stall;
    logic [23:0] o_fluctuation, o_window_start;
    int          fail_count, pending;
    int          cycles;
    logic        long_hold;
    logic        calm;
    logic [23:0] t_cur, y_cur;

    sliding_window_detrended_rms u_top (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .i_valid, .o_stall, .i_time_value, .i_profile_value,
        .i_start_of_series, .o_valid, .i_stall, .o_fluctuation, .o_window_start
    );

    swdr_checker u_checker (
        .i_clk, .i_rst_n, .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_time_value,
        .i_profile_value, .i_start_of_series, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_fluctuation(o_fluctuation),
        .i_window_start(o_window_start), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_sliding_window_detrended_rms: FAIL");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                n = calm ? 0 : $urandom_range(0, 12);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_sample(logic [23:0] t, logic [23:0] y, logic sos);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_time_value      <= t;
        i_profile_value   <= y;
        i_start_of_series <= sos;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_wlen(logic [31:0] v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= RegWindowLength;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one series: time rising by a fixed step or held constant, random-walk or random profile
    task automatic send_series(int len);
        logic [23:0] step;
        int          kind;
        kind  = $urandom_range(0, 9);
        step  = (kind == 0) ? 24'd0 : 24'($urandom_range(1, 4096));
        t_cur = 24'($urandom);
        y_cur = 24'($urandom);
        for (int k = 0; k < len; k++) begin
            t_cur = t_cur + step;
            if (kind == 1) y_cur = 24'($urandom);
            else y_cur = y_cur + 24'($signed($urandom_range(0, 16384)) - 8192);
            send_sample(t_cur, y_cur, k == 0);
        end
    endtask

    initial begin
        int sent;
        cycles    = 0;
        long_hold = 1'b0;
        calm      = 1'b0;
        i_rst_n   = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_time_value = '0; i_profile_value = '0;
        i_start_of_series = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset length first, then W = 3 extremes
        for (int k = 0; k < 17; k++)
            send_sample(24'(k * 4096), 24'($urandom), 1'b0);
        write_wlen(3);
        send_sample(24'h800000, 24'h800000, 1'b1);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 24'h7FFFFF, 1'b0);
        send_sample(24'h7FFFFF, 24'h800000, 1'b0);
        send_sample(24'h123456, 24'h000000, 1'b1);
        send_sample(24'h123456, 24'hFFFFFF, 1'b0);
        send_sample(24'h123456, 24'h7FFFFF, 1'b0);
        send_sample(24'h123456, 24'h800000, 1'b0);
        send_sample(24'h000000, 24'h000000, 1'b0);

        // random phases across window settings
        sent = 0;
        while (sent < 1200) begin
            case ($urandom_range(0, 7))
                0: write_wlen(0);
                1: write_wlen(3);
                2: write_wlen(511);
                3: write_wlen(256);
                default: write_wlen($urandom_range(3, 12));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < 6; s++) begin
                if ($urandom_range(0, 4) == 0) begin
                    for (int k = 0; k < 10; k++)
                        send_sample(24'($urandom), 24'($urandom),
                                    ($urandom_range(0, 7) == 0));
                    sent += 10;
                end else begin
                    send_series($urandom_range(4, 40));
                    sent += 22;
                end
            end
            if (sent > 300 && sent < 450) begin
                write_wlen(3);
                long_hold = 1'b1;
                send_series(60);
                sent += 60;
                drain();
            end
        end
        write_wlen(256);
        calm = 1'b1;
        send_series(280);
        calm = 1'b0;

        drain();
        if (fail_count == 0) begin
            $display("tb_sliding_window_detrended_rms: PASS");
        end else begin
            $display("tb_sliding_window_detrended_rms: FAIL");
        end
        $finish;
    end
endmodule
